FILE: src/smpc_pkg.sv
// Shared constants, field codes and types of the shadow memory poison checker.
package smpc_pkg;

    // Memory geometry. The granule size is a power of two.
    localparam int MEMORY_BYTES        = 8388608;
    localparam int GRANULE_BYTES       = 8;
    localparam int HIGHEST_POISON_CODE = 3;

    localparam int GRANULE_COUNT = (MEMORY_BYTES + GRANULE_BYTES - 1) / GRANULE_BYTES;
    localparam int GRAN_SHIFT    = $clog2(GRANULE_BYTES);
    localparam int IDX_W         = $clog2(GRANULE_COUNT);
    localparam int ADDR_W        = $clog2(MEMORY_BYTES + 1);
    localparam int POS_W         = IDX_W + GRAN_SHIFT + 1;

    // Shadow entry layout.
    localparam int PERM_W = 6;
    localparam int CODE_W = 3;
    localparam int TAIL_W = 4;

    // Stream word widths.
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 8;

    // Opcodes.
    localparam logic [1:0] OP_POISON    = 2'd0;
    localparam logic [1:0] OP_UNPOISON  = 2'd1;
    localparam logic [1:0] OP_READ_CHK  = 2'd2;
    localparam logic [1:0] OP_WRITE_CHK = 2'd3;

    // Fault classes.
    localparam logic [1:0] FC_NONE   = 2'd0;
    localparam logic [1:0] FC_PERM   = 2'd1;
    localparam logic [1:0] FC_TAIL   = 2'd2;
    localparam logic [1:0] FC_POISON = 2'd3;

    // Permission bits and poison codes.
    localparam logic [PERM_W-1:0] PERM_ALL   = 6'h3F;
    localparam logic [PERM_W-1:0] PERM_READ  = 6'h01;
    localparam logic [PERM_W-1:0] PERM_WRITE = 6'h02;
    localparam logic [CODE_W-1:0] CODE_CLEAN = 3'd0;
    localparam logic [CODE_W-1:0] CODE_USER  = 3'd1;

    // Configuration register indexes.
    localparam logic [0:0] CFG_CHECKER_EN = 1'b0;
    localparam logic [0:0] CFG_EXC_EN     = 1'b1;

    typedef struct packed {
        logic [TAIL_W-1:0] tail;
        logic [CODE_W-1:0] code;
        logic [PERM_W-1:0] perms;
    } entry_t;

    localparam entry_t ENTRY_RESET = '{tail: '0, code: CODE_CLEAN, perms: PERM_ALL};

    // Operation in flight, as the granule unit sees it.
    typedef struct packed {
        logic [1:0]        op;
        logic [IDX_W-1:0]  gran;
        logic [ADDR_W-1:0] rs;
        logic [ADDR_W-1:0] re;
        logic [CODE_W-1:0] code;
    } job_t;

    // Verdict of the granule unit for one entry.
    typedef struct packed {
        logic              wr;
        entry_t            entry;
        logic [1:0]        fclass;
        logic [CODE_W-1:0] fcode;
    } gran_res_t;

    // Finished result of one operation.
    typedef struct packed {
        logic [1:0]        fclass;
        logic [CODE_W-1:0] fcode;
        logic              access;
    } result_t;

endpackage

FILE: src/smpc_shadow_ram.sv
// Shadow table storage: one write port, one registered read port.
module smpc_shadow_ram (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [smpc_pkg::IDX_W-1:0] wr_addr,
    input  smpc_pkg::entry_t          wr_data,
    input  logic [smpc_pkg::IDX_W-1:0] rd_addr,
    output smpc_pkg::entry_t          rd_data
);
    import smpc_pkg::*;

    entry_t mem [0:GRANULE_COUNT-1];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/smpc_gran_unit.sv
// Per-granule unit: new entry for poison/unpoison, fault verdict for checks.
module smpc_gran_unit (
    input  smpc_pkg::job_t      job,
    input  smpc_pkg::entry_t    entry,
    output smpc_pkg::gran_res_t res
);
    import smpc_pkg::*;

    logic [POS_W-1:0]  gs;
    logic [POS_W-1:0]  ge;
    logic [POS_W-1:0]  rs;
    logic [POS_W-1:0]  re;
    logic [POS_W-1:0]  ss;
    logic [POS_W-1:0]  se;
    logic [POS_W-1:0]  ts;
    logic              head_cut;
    logic              tail_cut;
    logic [PERM_W-1:0] mask;

    always_comb
    begin
        gs       = POS_W'({job.gran, {GRAN_SHIFT{1'b0}}});
        ge       = gs + POS_W'(GRANULE_BYTES);
        rs       = POS_W'(job.rs);
        re       = POS_W'(job.re);
        ss       = (rs > gs) ? rs : gs;
        se       = (re < ge) ? re : ge;
        head_cut = (ss != gs);
        tail_cut = (se != ge);
        mask     = (job.op == OP_WRITE_CHK) ? PERM_WRITE : PERM_READ;
        ts       = ge - POS_W'(entry.tail);

        res = '0;
        case (job.op)
            OP_POISON:
            begin
                res.wr          = 1'b1;
                res.entry.perms = PERM_ALL;
                res.entry.code  = job.code;
                // Range covers the end but not the start: tail is the covered count.
                res.entry.tail  = (!tail_cut && head_cut) ? TAIL_W'(ge - ss) : '0;
            end
            OP_UNPOISON:
            begin
                res.wr = 1'b1;
                if (!head_cut && tail_cut)
                begin
                    res.entry.perms = PERM_ALL;
                    res.entry.code  = (entry.code == CODE_CLEAN) ? CODE_USER : entry.code;
                    res.entry.tail  = TAIL_W'(ge - se);
                end
                else
                begin
                    res.entry = ENTRY_RESET;
                end
            end
            OP_READ_CHK, OP_WRITE_CHK:
            begin
                if ((entry.perms & mask) != mask)
                begin
                    res.fclass = FC_PERM;
                    res.fcode  = entry.code;
                end
                else if (entry.tail != '0)
                begin
                    // Tail set: only overlap with the tail bytes matters.
                    if ((re > ts) && (rs < ge))
                    begin
                        res.fclass = FC_TAIL;
                        res.fcode  = entry.code;
                    end
                end
                else if (entry.code != CODE_CLEAN)
                begin
                    res.fclass = FC_POISON;
                    res.fcode  = entry.code;
                end
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

endmodule

FILE: src/smpc_seq.sv
// Sequencer: clearing pass, range clipping and the granule scan loop.
module smpc_seq (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 opcode,
    input  logic [31:0]                address,
    input  logic [31:0]                length,
    input  logic [smpc_pkg::CODE_W-1:0] poison_code,
    input  logic                       checker_en,
    input  logic                       out_free,
    output logic                       done,
    output smpc_pkg::result_t          result,
    output smpc_pkg::job_t             job,
    input  smpc_pkg::gran_res_t        unit_res,
    output logic                       wr_en,
    output logic [smpc_pkg::IDX_W-1:0] wr_addr,
    output smpc_pkg::entry_t           wr_data,
    output logic [smpc_pkg::IDX_W-1:0] rd_addr
);
    import smpc_pkg::*;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_PRIME = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]        state_reg,  state_next;
    logic [IDX_W-1:0]  clr_reg,    clr_next;
    logic [1:0]        op_reg,     op_next;
    logic [ADDR_W-1:0] rs_reg,     rs_next;
    logic [ADDR_W-1:0] re_reg,     re_next;
    logic [CODE_W-1:0] code_reg,   code_next;
    logic [IDX_W-1:0]  g_reg,      g_next;
    logic [IDX_W-1:0]  last_reg,   last_next;
    logic [1:0]        fclass_reg, fclass_next;
    logic [CODE_W-1:0] fcode_reg,  fcode_next;

    logic [32:0]       sum;
    logic [32:0]       clip_end;
    logic              empty;
    logic [ADDR_W-1:0] start_pos;
    logic [ADDR_W-1:0] end_pos;
    logic [ADDR_W-1:0] end_m1;
    logic [ADDR_W-1:0] start_g_full;
    logic [ADDR_W-1:0] last_g_full;

    // Clip the range to memory.
    always_comb
    begin
        sum          = {1'b0, address} + {1'b0, length};
        clip_end     = (sum > 33'(MEMORY_BYTES)) ? 33'(MEMORY_BYTES) : sum;
        empty        = !checker_en || (length == 32'd0) || (clip_end <= {1'b0, address});
        start_pos    = address[ADDR_W-1:0];
        end_pos      = clip_end[ADDR_W-1:0];
        end_m1       = end_pos - ADDR_W'(1);
        start_g_full = start_pos >> GRAN_SHIFT;
        last_g_full  = end_m1 >> GRAN_SHIFT;
    end

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        op_next     = op_reg;
        rs_next     = rs_reg;
        re_next     = re_reg;
        code_next   = code_reg;
        g_next      = g_reg;
        last_next   = last_reg;
        fclass_next = fclass_reg;
        fcode_next  = fcode_reg;
        in_ready    = 1'b0;
        done        = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = g_reg;
        wr_data     = unit_res.entry;
        rd_addr     = g_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                wr_data  = ENTRY_RESET;
                clr_next = clr_reg + IDX_W'(1);
                if (clr_reg == IDX_W'(GRANULE_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next     = opcode;
                    rs_next     = start_pos;
                    re_next     = end_pos;
                    code_next   = (poison_code > CODE_W'(HIGHEST_POISON_CODE)) ?
                                  CODE_USER : poison_code;
                    g_next      = start_g_full[IDX_W-1:0];
                    last_next   = last_g_full[IDX_W-1:0];
                    fclass_next = FC_NONE;
                    fcode_next  = CODE_CLEAN;
                    state_next  = empty ? ST_DONE : ST_PRIME;
                end
            end
            ST_PRIME:
            begin
                // Fetch the first granule.
                rd_addr    = g_reg;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                // Evaluate granule g while fetching g+1.
                rd_addr = g_reg + IDX_W'(1);
                wr_en   = unit_res.wr;
                wr_addr = g_reg;
                wr_data = unit_res.entry;
                if (unit_res.fclass != FC_NONE)
                begin
                    fclass_next = unit_res.fclass;
                    fcode_next  = unit_res.fcode;
                    state_next  = ST_DONE;
                end
                else if (g_reg == last_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    g_next = g_reg + IDX_W'(1);
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    done       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        rs_reg     <= rs_next;
        re_reg     <= re_next;
        code_reg   <= code_next;
        g_reg      <= g_next;
        last_reg   <= last_next;
        fclass_reg <= fclass_next;
        fcode_reg  <= fcode_next;
    end

    assign job.op   = op_reg;
    assign job.gran = g_reg;
    assign job.rs   = rs_reg;
    assign job.re   = re_reg;
    assign job.code = code_reg;

    assign result.fclass = fclass_reg;
    assign result.fcode  = fcode_reg;
    assign result.access = (fclass_reg != FC_NONE) && (op_reg == OP_WRITE_CHK);

endmodule

FILE: src/shadow_memory_poison_checker_core.sv
// Top level of the shadow memory poison checker.
//
// Usage: each word on the s_axis channel is one operation: poison or unpoison
// a byte range, or check a read or write access against the shadow table.
// Ranges are clipped to the memory size. Every operation returns exactly one
// word on the m_axis channel: a fault flag, the fault class, the poison code of
// the faulting granule, the access kind and an exception request.
// The cfg channel writes checker_enable (index 0) and exception_enable
// (index 1); it is always ready. The user must write it only while no
// operation is in flight; the block itself leaves this unenforced.
// Timing: the shadow table has one write and one registered read port, and the
// scan visits one granule per cycle through that read port. An operation
// holds s_axis_tready low through a priming read, the scan and a done state
// that waits while the output register is full; an empty, clipped away or
// disabled operation skips to done. A check stops at its first fault.
// Reset: control state clears, both registers go to zero, and a clearing pass
// writes every one of the 1,048,576 table entries back to full permissions,
// one per cycle, with s_axis_tready low throughout.
// Backpressure: the result sits in an output register until m_axis_tready;
// the next operation may be accepted meanwhile, and a finished operation
// waits in place if the register is still full.
module shadow_memory_poison_checker_core (
    input  logic                           clk,
    input  logic                           rst_n,
    // opcode[1:0], address[33:2], length[65:34], poison_code[68:66], zero pad
    input  logic [smpc_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // fault[0], fault_class[2:1], fault_poison[5:3], fault_access[6],
    // raise_exception[7]
    output logic [smpc_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [0:0]                     cfg_index,
    input  logic                           cfg_data
);
    import smpc_pkg::*;

    logic                 checker_en_reg, checker_en_next;
    logic                 exc_en_reg,     exc_en_next;
    logic                 out_valid_reg,  out_valid_next;
    logic [M_TDATA_W-1:0] out_data_reg,   out_data_next;

    logic                 out_free;
    logic                 done;
    logic                 fault;
    result_t              result;
    job_t                 job;
    gran_res_t            unit_res;
    entry_t               rd_data;
    entry_t               wr_data;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [IDX_W-1:0]     rd_addr;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_axis_tready;

    smpc_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .opcode      (s_axis_tdata[1:0]),
        .address     (s_axis_tdata[33:2]),
        .length      (s_axis_tdata[65:34]),
        .poison_code (s_axis_tdata[68:66]),
        .checker_en  (checker_en_reg),
        .out_free    (out_free),
        .done        (done),
        .result      (result),
        .job         (job),
        .unit_res    (unit_res),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rd_addr     (rd_addr)
    );

    smpc_gran_unit u_unit (
        .job   (job),
        .entry (rd_data),
        .res   (unit_res)
    );

    smpc_shadow_ram u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Configuration writes.
    always_comb
    begin
        checker_en_next = checker_en_reg;
        exc_en_next     = exc_en_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_CHECKER_EN: checker_en_next = cfg_data;
                CFG_EXC_EN:     exc_en_next     = cfg_data;
                default:        checker_en_next = checker_en_reg;
            endcase
        end
    end

    // Output register: load on done, drop when taken.
    assign fault = (result.fclass != FC_NONE);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (done)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {fault && exc_en_reg, result.access, result.fcode,
                              result.fclass, fault};
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            checker_en_reg <= 1'b0;
            exc_en_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            checker_en_reg <= checker_en_next;
            exc_en_reg     <= exc_en_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

FILE: src/smpc_checker.sv
// Port-level assertions for the checker core, bound to the top level.
module smpc_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic [smpc_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready
);
    import smpc_pkg::*;

    // One operation at a time: ready drops right after an accept.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while an operation is in flight");

    // An exception request comes only with a fault.
    a_exc_needs_fault: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[7] |-> m_axis_tdata[0])
        else $error("exception request without fault");

    // A passing result carries all-zero fields.
    a_pass_is_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[7:1] == 7'd0)
        else $error("passing result with nonzero fields");

    // A fault names a class.
    a_fault_has_class: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[2:1] != FC_NONE)
        else $error("fault with class none");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

endmodule

bind shadow_memory_poison_checker_core smpc_checker u_smpc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);
